>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the sight-line cross product block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHECK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CHECK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/fpts_pkg.sv
// Package for the sight-line cross product block: widths, stage counts,
// payload structs and register indexes. Depends on nothing.
`timescale 1ns / 1ps

package fpts_pkg;

  localparam int CW          = 32;              // coordinate width, Q16.16
  localparam int MW          = CW + 1;          // offset magnitude width
  localparam int NW          = 31;              // normalized magnitude width
  localparam int UF          = 30;              // fraction bits of the unit vector
  localparam int SQW         = 2 * NW;          // one square
  localparam int SUMW        = 2 * NW + 2;      // sum of three squares
  localparam int LENW        = SUMW / 2;        // square root width
  localparam int NUMW        = NW + UF + 1;     // dividend width
  localparam int QW          = UF + 1;          // quotient width
  localparam int UW          = UF + 2;          // signed unit component width
  localparam int PW          = UW + CW;         // product width
  localparam int DW          = PW + 1;          // difference width
  localparam int BLW         = $clog2(MW + 1);  // bit length width
  localparam int SHW         = MW + NW;         // normalizing shifter width
  localparam int SQRT_STAGES = LENW;
  localparam int DIV_STAGES  = QW;
  localparam int LANE_LAT    = DIV_STAGES + 2;
  localparam int CROSS_LAT   = 2;
  localparam int FRONT_LAT   = 5;
  localparam int SIDE_LAT    = SQRT_STAGES + LANE_LAT;
  localparam int VLD_LAT     = FRONT_LAT + SIDE_LAT + CROSS_LAT;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [UW-1:0] unit_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_OBS_X = 2'd0,
    REG_OBS_Y = 2'd1,
    REG_OBS_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t field_x;
    coord_t field_y;
    coord_t field_z;
  } in_t;

  typedef struct packed {
    coord_t perp_x;
    coord_t perp_y;
    coord_t perp_z;
    logic   zero_distance;
    logic   saturated;
  } out_t;

  // Normalized magnitudes and signs waiting for the square root.
  typedef struct packed {
    logic [2:0][NW-1:0] nmag;
    logic [2:0]         neg;
  } nd_t;

  // Field and zero flag waiting for the unit vector.
  typedef struct packed {
    coord_t [2:0] fld;
    logic         zero;
  } side_t;

endpackage

>>> rtl/fpts_isqrt.sv
// Pipelined bit-by-bit integer square root, one result bit per stage.
// Depends on fpts_pkg.
`timescale 1ns / 1ps

module fpts_isqrt
  import fpts_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [SUMW-1:0] n,
  output logic [LENW-1:0] root
);

  logic [SUMW-1:0] rem [SQRT_STAGES];
  logic [SUMW-1:0] acc [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [SUMW-1:0] BIT = SUMW'(1) << (SUMW - 2 - 2 * k);
    logic [SUMW-1:0] rem_in;
    logic [SUMW-1:0] acc_in;
    logic [SUMW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = n;
      assign acc_in = '0;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign acc_in = acc[k-1];
    end

    assign trial = acc_in + BIT;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? rem_in - trial : rem_in;
        acc[k] <= ge ? (acc_in >> 1) + BIT : (acc_in >> 1);
      end
    end
  end

  assign root = acc[SQRT_STAGES-1][LENW-1:0];

endmodule

>>> rtl/fpts_lane.sv
// One direction lane: rounded restoring division of a normalized magnitude
// by the length, one quotient bit per stage, then the sign. Depends on fpts_pkg.
`timescale 1ns / 1ps

module fpts_lane
  import fpts_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   nmag,
  input  logic            neg,
  input  logic [LENW-1:0] len,
  output unit_t           u
);

  logic [NUMW-1:0] rem [DIV_STAGES+1];
  logic [QW-1:0]   quo [DIV_STAGES+1];
  logic [LENW-1:0] den [DIV_STAGES+1];
  logic            sgn [DIV_STAGES+1];

  // Dividend carries half the divisor so that the quotient comes out rounded.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= NUMW'({nmag, {UF{1'b0}}}) + NUMW'(len >> 1);
      quo[0] <= '0;
      den[0] <= len;
      sgn[0] <= neg;
    end
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_stage
    localparam int B = DIV_STAGES - j;
    logic [NUMW:0] shifted;
    logic [NUMW:0] diff;
    logic          take;

    assign shifted = (NUMW+1)'(den[j-1]) << B;
    assign diff    = {1'b0, rem[j-1]} - shifted;
    assign take    = !diff[NUMW];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= take ? diff[NUMW-1:0] : rem[j-1];
        quo[j] <= quo[j-1] | (QW'(take) << B);
        den[j] <= den[j-1];
        sgn[j] <= sgn[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u <= sgn[DIV_STAGES] ? unit_t'(-{1'b0, quo[DIV_STAGES]})
                           : unit_t'({1'b0, quo[DIV_STAGES]});
    end
  end

endmodule

>>> rtl/fpts_cross.sv
// Merge stage: cross product of the unit vector with the field, rounding
// to Q16.16 and clipping. Depends on fpts_pkg.
`timescale 1ns / 1ps

module fpts_cross
  import fpts_pkg::*;
(
  input  logic         clk,
  input  logic         en,
  input  unit_t        u_x,
  input  unit_t        u_y,
  input  unit_t        u_z,
  input  coord_t [2:0] fld,
  output coord_t [2:0] perp,
  output logic         sat
);

  localparam logic signed [DW-1:0] RND = DW'(1) << (UF - 1);

  logic signed [PW-1:0]    prod [6];
  logic signed [DW-1:0]    acc  [3];
  logic signed [DW-UF-1:0] sh   [3];
  logic [2:0]              clip;

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= u_y * fld[2];
      prod[1] <= u_z * fld[1];
      prod[2] <= u_z * fld[0];
      prod[3] <= u_x * fld[2];
      prod[4] <= u_x * fld[1];
      prod[5] <= u_y * fld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= DW'(prod[2*i]) - DW'(prod[2*i+1]) + RND;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = (DW-UF)'(acc[i] >>> UF);
      if (sh[i] > (DW-UF)'(COORD_MAX)) begin
        perp[i] = COORD_MAX;
        clip[i] = 1'b1;
      end else if (sh[i] < (DW-UF)'(COORD_MIN)) begin
        perp[i] = COORD_MIN;
        clip[i] = 1'b1;
      end else begin
        perp[i] = coord_t'(sh[i]);
        clip[i] = 1'b0;
      end
    end
    sat = |clip;
  end

endmodule

>>> rtl/field_perpendicular_to_sightline.sv
// Top level of the sight-line cross product block: observer registers, the
// offset and normalizing front end, and the pipeline around the submodules.
// Depends on fpts_pkg, fpts_isqrt, fpts_lane, fpts_cross and assert_macros.svh.
//
// Each input item carries a point and the field at that point, signed Q16.16.
// The block forms the offset from the observer (APB registers at byte offsets
// 0, 4 and 8), scales it to a unit direction and returns direction x field,
// rounded and clipped to Q16.16, with zero_distance and saturated flags.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The pipeline is fully registered and takes one item every cycle
// while out_stall does not hold a waiting result. The accepting edge loads
// the first of 73 register stages, and out_valid rises with the result in the
// last. The stages are five in the front end, 32 square-root stages, 33 in
// each of the three direction lanes (dividend setup, 31 quotient bits and the
// sign), two cross-product stages and the output register.
// The square root and the dividers, one bit per stage, set that depth.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped. Reset clears the
// observer registers and all valid bits, so the block comes up empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module field_perpendicular_to_sightline
  import fpts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  coord_t [2:0] obs;
  reg_idx_t     ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      obs <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_OBS_X: obs[0] <= coord_t'(pwdata);
        REG_OBS_Y: obs[1] <= coord_t'(pwdata);
        REG_OBS_Z: obs[2] <= coord_t'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_OBS_X: prdata = DATA_W'(obs[0]);
      REG_OBS_Y: prdata = DATA_W'(obs[1]);
      REG_OBS_Z: prdata = DATA_W'(obs[2]);
      default:   prdata = '0;
    endcase
  end

  // One enable moves every stage; it drops only while a result waits stalled.
  logic               en;
  logic [VLD_LAT-1:0] vld;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[VLD_LAT-2:0], in_valid};
      out_valid <= vld[VLD_LAT-1];
    end
  end

  // Stage 1: offset from the observer, split into sign and magnitude.
  coord_t [2:0]              pos_a;
  coord_t [2:0]              fld_a;
  logic signed [2:0][MW-1:0] d_c;
  logic [2:0][MW-1:0]        mag_c;
  logic [2:0][MW-1:0]        mag1;
  logic [2:0]                neg1;
  coord_t [2:0]              fld1;

  assign pos_a = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign fld_a = {in_data.field_z, in_data.field_y, in_data.field_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]   = MW'(pos_a[i]) - MW'(obs[i]);
      mag_c[i] = d_c[i][MW-1] ? MW'(-d_c[i]) : MW'(d_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag_c;
      for (int i = 0; i < 3; i++) neg1[i] <= d_c[i][MW-1];
      fld1 <= fld_a;
    end
  end

  // Stage 2: bit length of the largest magnitude, taken from the OR of all three.
  logic [MW-1:0]      orm;
  logic [BLW-1:0]     blen_c;
  logic [2:0][MW-1:0] mag2;
  logic [2:0]         neg2;
  coord_t [2:0]       fld2;
  logic [BLW-1:0]     blen2;
  logic               zero2;

  assign orm = mag1[0] | mag1[1] | mag1[2];

  always_comb begin
    blen_c = '0;
    for (int i = 0; i < MW; i++) begin
      if (orm[i]) blen_c = BLW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2  <= mag1;
      neg2  <= neg1;
      fld2  <= fld1;
      blen2 <= blen_c;
      zero2 <= (orm == '0);
    end
  end

  // Stage 3: shift all magnitudes together so the largest fills NW bits.
  logic [2:0][NW-1:0] nmag_c;
  logic [2:0][NW-1:0] nmag3;
  logic [2:0]         neg3;
  coord_t [2:0]       fld3;
  logic               zero3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (blen2 > BLW'(NW)) begin
        nmag_c[i] = NW'(SHW'(mag2[i]) >> (blen2 - BLW'(NW)));
      end else begin
        nmag_c[i] = NW'(SHW'(mag2[i]) << (BLW'(NW) - blen2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmag3 <= nmag_c;
      neg3  <= neg2;
      fld3  <= fld2;
      zero3 <= zero2;
    end
  end

  // Stages 4 and 5: squares, then their sum.
  logic [2:0][SQW-1:0] sq4;
  nd_t                 nd4;
  side_t               side4;
  logic [SUMW-1:0]     sum5;
  nd_t                 nd5;
  side_t               side5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq4[i] <= SQW'(nmag3[i]) * SQW'(nmag3[i]);
      nd4   <= '{nmag: nmag3, neg: neg3};
      side4 <= '{fld: fld3, zero: zero3};
      sum5  <= SUMW'(sq4[0]) + SUMW'(sq4[1]) + SUMW'(sq4[2]);
      nd5   <= nd4;
      side5 <= side4;
    end
  end

  logic [LENW-1:0] len;

  fpts_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .n    (sum5),
    .root (len)
  );

  // Magnitudes wait out the square root; field and flag wait for the lanes too.
  nd_t   nd_q   [SQRT_STAGES];
  side_t side_q [SIDE_LAT];
  logic  zero_q [CROSS_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      nd_q[0] <= nd5;
      for (int k = 1; k < SQRT_STAGES; k++) nd_q[k] <= nd_q[k-1];
      side_q[0] <= side5;
      for (int k = 1; k < SIDE_LAT; k++) side_q[k] <= side_q[k-1];
      zero_q[0] <= side_q[SIDE_LAT-1].zero;
      for (int k = 1; k < CROSS_LAT; k++) zero_q[k] <= zero_q[k-1];
    end
  end

  unit_t u [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    fpts_lane u_lane (
      .clk  (clk),
      .en   (en),
      .nmag (nd_q[SQRT_STAGES-1].nmag[i]),
      .neg  (nd_q[SQRT_STAGES-1].neg[i]),
      .len  (len),
      .u    (u[i])
    );
  end

  coord_t [2:0] perp;
  logic         sat;

  fpts_cross u_cross (
    .clk  (clk),
    .en   (en),
    .u_x  (u[0]),
    .u_y  (u[1]),
    .u_z  (u[2]),
    .fld  (side_q[SIDE_LAT-1].fld),
    .perp (perp),
    .sat  (sat)
  );

  // A point on the observer gives a zero vector and no clipping.
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_q[CROSS_LAT-1]) begin
        out_data <= '{perp_x: '0, perp_y: '0, perp_z: '0,
                      zero_distance: 1'b1, saturated: 1'b0};
      end else begin
        out_data <= '{perp_x: perp[0], perp_y: perp[1], perp_z: perp[2],
                      zero_distance: 1'b0, saturated: sat};
      end
    end
  end

  // Summaries of the output word used by the checks below.
  logic perp_zero;
  logic perp_at_rail;

  assign perp_zero = (out_data.perp_x == '0) && (out_data.perp_y == '0) &&
                     (out_data.perp_z == '0) && !out_data.saturated;
  assign perp_at_rail = (out_data.perp_x == COORD_MAX) || (out_data.perp_x == COORD_MIN) ||
                        (out_data.perp_y == COORD_MAX) || (out_data.perp_y == COORD_MIN) ||
                        (out_data.perp_z == COORD_MAX) || (out_data.perp_z == COORD_MIN);

  `CHECK_IMPLY(a_zero_clean, clk, rst, out_valid && out_data.zero_distance, perp_zero)

  `CHECK_NEXT(a_hold_pipe, clk, rst, in_stall, $stable(vld))

  `CHECK_IMPLY(a_sat_clip, clk, rst, out_valid && out_data.saturated, perp_at_rail)

endmodule

>>> tb/sightline_scoreboard.sv
// Scoreboard for the sight-line cross product block: predicts each result from
// the accepted item and the observer position, then checks results in order.
// Depends on fpts_pkg for the payload structs and the coordinate limits.
`timescale 1ns / 1ps

class sightline_scoreboard;
  fpts_pkg::coord_t   obs[3];
  fpts_pkg::out_t     want_q[$];
  int                 mismatches;
  int                 checked;
  int                 zero_seen;
  int                 sat_seen;

  function new();
    obs = '{0, 0, 0};
  endfunction

  function void set_observer(int idx, fpts_pkg::coord_t v);
    obs[idx] = v;
  endfunction

  function longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Round the Q2.30 x Q16.16 product back to Q16.16 and clip it.
  function fpts_pkg::coord_t round_clip(logic signed [127:0] p, inout bit sat);
    logic signed [127:0] s;
    s = (p + (128'sd1 <<< 29)) >>> 30;
    if (s > 128'sd2147483647) begin
      sat = 1;
      return fpts_pkg::COORD_MAX;
    end
    if (s < -128'sd2147483648) begin
      sat = 1;
      return fpts_pkg::COORD_MIN;
    end
    return s[31:0];
  endfunction

  function fpts_pkg::out_t cross_with_unit(fpts_pkg::in_t x);
    fpts_pkg::coord_t    pc[3];
    fpts_pkg::coord_t    fc[3];
    logic signed [33:0]  d;
    logic [63:0]         mag[3];
    bit                  neg[3];
    logic [63:0]         m, sumsq, len, q;
    logic signed [127:0] u[3], f[3];
    int                  blen;
    bit                  sat;
    fpts_pkg::out_t      r;
    pc = '{x.pos_x, x.pos_y, x.pos_z};
    fc = '{x.field_x, x.field_y, x.field_z};
    m = 0;
    sat = 0;
    for (int i = 0; i < 3; i++) begin
      d = {{2{pc[i][31]}}, pc[i]} - {{2{obs[i][31]}}, obs[i]};
      neg[i] = d[33];
      mag[i] = neg[i] ? 64'(-d) : 64'(d);
      if (mag[i] > m) m = mag[i];
      f[i] = fc[i];
    end
    r = '0;
    if (m == 0) begin
      r.zero_distance = 1'b1;
      return r;
    end
    blen = 0;
    while (blen < 64 && (m >> blen) != 0) blen++;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      if (blen > 31) mag[i] = mag[i] >> (blen - 31);
      else mag[i] = mag[i] << (31 - blen);
      sumsq = sumsq + mag[i] * mag[i];
    end
    len = floor_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (len >> 1)) / len;
      u[i] = $signed({64'd0, q});
      if (neg[i]) u[i] = -u[i];
    end
    r.perp_x = round_clip(u[1] * f[2] - u[2] * f[1], sat);
    r.perp_y = round_clip(u[2] * f[0] - u[0] * f[2], sat);
    r.perp_z = round_clip(u[0] * f[1] - u[1] * f[0], sat);
    r.saturated = sat;
    return r;
  endfunction

  function void note_item(fpts_pkg::in_t x);
    want_q = {want_q, cross_with_unit(x)};
  endfunction

  function void check_result(fpts_pkg::out_t got);
    fpts_pkg::out_t want;
    if (want_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = want_q.pop_front();
    checked++;
    if (want.zero_distance) zero_seen++;
    if (want.saturated) sat_seen++;
    if (got.perp_x !== want.perp_x || got.perp_y !== want.perp_y ||
        got.perp_z !== want.perp_z || got.zero_distance !== want.zero_distance ||
        got.saturated !== want.saturated) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: expected x=%h y=%h z=%h zd=%b sat=%b",
                 checked, want.perp_x, want.perp_y, want.perp_z,
                 want.zero_distance, want.saturated);
        $display("result %0d: got      x=%h y=%h z=%h zd=%b sat=%b",
                 checked, got.perp_x, got.perp_y, got.perp_z,
                 got.zero_distance, got.saturated);
      end
    end
  endfunction
endclass

>>> tb/field_perpendicular_to_sightline_tb.sv
// Testbench top for the sight-line cross product block: drives items and
// observer writes, with random idling on both sides and one long output hold.
// Depends on fpts_pkg, sightline_scoreboard.sv and the block's RTL.
`timescale 1ns / 1ps

module field_perpendicular_to_sightline_tb;
  import fpts_pkg::*;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sightline_scoreboard sb = new();

  // Receiver behavior: quiet turns off all stalling, hold_req asks for one
  // long hold so the pipeline fills up and pushes back on the input.
  bit quiet;
  bit hold_req;
  bit hold_done;
  int items_sent;

  // Directed items waiting to be sent.
  in_t dir_q[$];

  field_perpendicular_to_sightline u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Both handshakes are observed at the rising edge, where all inputs have
  // been steady since the falling edge before.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Receiver: random stall bursts, one long hold on request, none when quiet.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1;
        repeat (250) @(negedge clk);
        out_stall <= 0;
        hold_req = 0;
        hold_done = 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_stall <= 0;
        if (!quiet) repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  // One APB write: setup cycle, then the access cycle that commits it.
  task automatic write_observer(reg_idx_t idx, coord_t v);
    @(negedge clk);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    sb.set_observer(int'(idx), v);
  endtask

  task automatic set_observer_all(coord_t x, coord_t y, coord_t z);
    write_observer(REG_OBS_X, x);
    write_observer(REG_OBS_Y, y);
    write_observer(REG_OBS_Z, z);
  endtask

  // Offer one item and hold it until the block takes it. Valid stays high
  // from one item to the next unless a gap is inserted.
  task automatic send_item(in_t x);
    @(negedge clk);
    in_valid <= 1;
    in_data  <= x;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  task automatic sender_gap(int n);
    @(negedge clk);
    in_valid <= 0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Registers change only with nothing in flight.
  task automatic drain();
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Coordinate mix: extremes, zero, values near the observer, and full random.
  function automatic coord_t pick_coord(int axis);
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return 0;
      3, 4:    return sb.obs[axis] + coord_t'($signed($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_field();
    case ($urandom_range(0, 5))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t x;
    x.pos_x   = pick_coord(0);
    x.pos_y   = pick_coord(1);
    x.pos_z   = pick_coord(2);
    // Now and then the point sits right on the observer.
    if ($urandom_range(0, 29) == 0) begin
      x.pos_x = sb.obs[0];
      x.pos_y = sb.obs[1];
      x.pos_z = sb.obs[2];
    end
    x.field_x = pick_field();
    x.field_y = pick_field();
    x.field_z = pick_field();
    return x;
  endfunction

  task automatic random_phase(int n, bit gaps, bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_req = 1;
      if (gaps && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 18));
      send_item(random_item());
    end
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic in_t mk(coord_t px, coord_t py, coord_t pz,
                             coord_t fx, coord_t fy, coord_t fz);
    mk = '{px, py, pz, fx, fy, fz};
  endfunction

  // Append one directed item to the list.
  function automatic void queue_dir(coord_t px, coord_t py, coord_t pz,
                                    coord_t fx, coord_t fy, coord_t fz);
    dir_q = {dir_q, mk(px, py, pz, fx, fy, fz)};
  endfunction

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    quiet = 0;
    hold_req = 0;
    hold_done = 0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: observer at the origin. Zero offset, single axes, offsets
    // so small they are shifted up, the largest offsets and fields that
    // push the cross product into saturation.
    queue_dir(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    queue_dir(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
    queue_dir(0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000);
    queue_dir(0, 0, -32'sh0001_0000, 32'h0001_0000, 0, 0);
    queue_dir(1, 0, 0, 0, COORD_MAX, COORD_MIN);
    queue_dir(1, 1, 1, COORD_MAX, COORD_MIN, 0);
    queue_dir(-1, 1, -1, 0, 0, 0);
    queue_dir(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    queue_dir(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_dir(COORD_MAX, 0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    queue_dir(COORD_MIN, 1, 0, 0, COORD_MAX, COORD_MAX);
    queue_dir(32'h0003_0000, 32'h0004_0000, 0, COORD_MAX, COORD_MAX, COORD_MAX);
    foreach (dir_q[i]) send_item(dir_q[i]);
    @(negedge clk);
    in_valid <= 0;
    drain();

    // Observer at opposite extremes: offsets reach the full 33-bit range.
    dir_q.delete();
    set_observer_all(COORD_MIN, COORD_MAX, COORD_MIN);
    queue_dir(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
    queue_dir(COORD_MIN, COORD_MAX, COORD_MIN, 5, 6, 7);
    queue_dir(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0);
    queue_dir(COORD_MAX, COORD_MAX, COORD_MIN, 0, COORD_MAX, COORD_MIN);
    foreach (dir_q[i]) send_item(dir_q[i]);
    @(negedge clk);
    in_valid <= 0;
    random_phase(350, 1, 0);
    drain();

    set_observer_all(COORD_MAX, COORD_MIN, COORD_MAX);
    random_phase(350, 1, 1);
    drain();

    set_observer_all(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    random_phase(350, 1, 0);
    drain();

    set_observer_all(0, 0, 0);
    random_phase(300, 1, 0);
    drain();

    // Closing stretch at full rate on both sides.
    set_observer_all(coord_t'($urandom), 32'h0000_0001, -32'sh0000_0001);
    quiet = 1;
    random_phase(250, 0, 0);
    drain();

    $display("Sent %0d items over six observer settings; %0d results checked,",
             items_sent, sb.checked);
    $display("%0d with zero offset, %0d clipped; long output hold done: %0d.",
             sb.zero_seen, sb.sat_seen, hold_done);
    if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("Mismatches: %0d.", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding.", sb.want_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
